FILE: src/mfh_pkg.sv
// Package for the MQTT fixed-header deframer: widths, phase and event codes,
// and the result record. No dependencies.
package mfh_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned LEN_W  = 28;
    localparam int unsigned NIB_W  = 4;
    localparam int unsigned EV_W   = 3;
    localparam int unsigned IDX_W  = 2;

    localparam logic [LEN_W-1:0] MAX_LEN_RESET = LEN_W'(256 * 1024);
    localparam logic [IDX_W-1:0] LEN_IDX_LAST  = IDX_W'(3);

    typedef enum logic [1:0] {
        PH_CONTROL = 2'd0,
        PH_LENGTH  = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_HALTED  = 2'd3
    } t_phase;

    typedef enum logic [EV_W-1:0] {
        EV_HEADER   = 3'd0,
        EV_COMPLETE = 3'd1,
        EV_PAYLOAD  = 3'd2,
        EV_BADLEN   = 3'd3,
        EV_TOOLARGE = 3'd4,
        EV_DROPPED  = 3'd5
    } t_event;

    typedef struct packed {
        t_event             event_res;
        logic [NIB_W-1:0]   pkt_type;
        logic [NIB_W-1:0]   packet_flags;
        logic [LEN_W-1:0]   rem_length;
        logic [BYTE_W-1:0]  payload_byte;
        logic               last;
    } t_result;

endpackage

FILE: src/mfh_if.sv
// Valid/ready channel interfaces of the deframer: byte stream in, results out,
// and the maximum-length register write. Depends on mfh_pkg.
interface mfh_in_if;
    import mfh_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] stream_byte;
    modport source (output valid, output stream_byte, input ready);
    modport sink   (input valid, input stream_byte, output ready);
endinterface

interface mfh_out_if;
    import mfh_pkg::*;
    logic              valid;
    logic              ready;
    logic [EV_W-1:0]   event_res;
    logic [NIB_W-1:0]  pkt_type;
    logic [NIB_W-1:0]  packet_flags;
    logic [LEN_W-1:0]  rem_length;
    logic [BYTE_W-1:0] payload_byte;
    logic              last;
    modport source (output valid, output event_res, output pkt_type, output packet_flags,
                    output rem_length, output payload_byte, output last, input ready);
    modport sink   (input valid, input event_res, input pkt_type, input packet_flags,
                    input rem_length, input payload_byte, input last, output ready);
endinterface

interface mfh_cfg_if;
    import mfh_pkg::*;
    logic             valid;
    logic             ready;
    logic [LEN_W-1:0] max_rem_length;
    modport source (output valid, output max_rem_length, input ready);
    modport sink   (input valid, input max_rem_length, output ready);
endinterface

FILE: src/mfh_core.sv
// Per-byte deframing state machine: phase, length decode, payload count and
// the result of one byte. Depends on mfh_pkg.
module mfh_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_step,
    input  logic [mfh_pkg::BYTE_W-1:0]   i_byte,
    input  logic [mfh_pkg::LEN_W-1:0]    i_max_len,
    output mfh_pkg::t_result             o_res
);
    import mfh_pkg::*;

    t_phase             r_phase, n_phase;
    logic [LEN_W-1:0]   r_acc, n_acc;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [LEN_W-1:0]   r_left, n_left;
    logic [NIB_W-1:0]   r_type, n_type;
    logic [NIB_W-1:0]   r_flags, n_flags;

    logic [LEN_W-1:0]   w_group;
    logic [LEN_W-1:0]   w_acc_sum;
    logic [LEN_W-1:0]   w_left_dec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_CONTROL;
            r_acc   <= '0;
            r_idx   <= '0;
            r_left  <= '0;
            r_type  <= '0;
            r_flags <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_idx   <= n_idx;
            r_left  <= n_left;
            r_type  <= n_type;
            r_flags <= n_flags;
        end
    end

    always_comb begin
        case (r_idx)
            2'd0:    w_group = {21'd0, i_byte[6:0]};
            2'd1:    w_group = {14'd0, i_byte[6:0], 7'd0};
            2'd2:    w_group = {7'd0, i_byte[6:0], 14'd0};
            default: w_group = {i_byte[6:0], 21'd0};
        endcase
    end

    assign w_acc_sum  = r_acc + w_group;
    assign w_left_dec = r_left - LEN_W'(1);

    always_comb begin
        n_phase = r_phase;
        n_acc   = r_acc;
        n_idx   = r_idx;
        n_left  = r_left;
        n_type  = r_type;
        n_flags = r_flags;

        o_res.event_res    = EV_DROPPED;
        o_res.pkt_type     = r_type;
        o_res.packet_flags = r_flags;
        o_res.rem_length   = '0;
        o_res.payload_byte = '0;
        o_res.last         = 1'b0;

        case (r_phase)
            PH_CONTROL: begin
                n_type  = i_byte[7:4];
                n_flags = i_byte[3:0];
                n_acc   = '0;
                n_idx   = '0;
                n_left  = '0;
                n_phase = PH_LENGTH;
                o_res.event_res    = EV_HEADER;
                o_res.pkt_type     = i_byte[7:4];
                o_res.packet_flags = i_byte[3:0];
            end
            PH_LENGTH: begin
                n_acc = w_acc_sum;
                if (i_byte[7]) begin
                    if (r_idx == LEN_IDX_LAST) begin
                        n_phase         = PH_HALTED;
                        o_res.event_res = EV_BADLEN;
                    end else begin
                        n_idx           = r_idx + IDX_W'(1);
                        o_res.event_res = EV_HEADER;
                    end
                end else if (w_acc_sum > i_max_len) begin
                    n_phase          = PH_HALTED;
                    o_res.event_res  = EV_TOOLARGE;
                    o_res.rem_length = w_acc_sum;
                end else begin
                    n_left           = w_acc_sum;
                    n_phase          = (w_acc_sum == '0) ? PH_CONTROL : PH_PAYLOAD;
                    o_res.event_res  = EV_COMPLETE;
                    o_res.rem_length = w_acc_sum;
                    o_res.last       = (w_acc_sum == '0);
                end
            end
            PH_PAYLOAD: begin
                n_left = w_left_dec;
                if (w_left_dec == '0) begin
                    n_phase = PH_CONTROL;
                end
                o_res.event_res    = EV_PAYLOAD;
                o_res.rem_length   = r_acc;
                o_res.payload_byte = i_byte;
                o_res.last         = (w_left_dec == '0);
            end
            default: begin
                o_res.event_res = EV_DROPPED;
            end
        endcase
    end

endmodule

FILE: src/mqtt_fixed_header_deframer.sv
// MQTT fixed-header deframer top level: input register, deframing core,
// result register and the maximum-length register. Depends on mfh_pkg, mfh_if, mfh_core.
// Each accepted byte passes the input register, then the core, then the result register.
// Throughput: one byte per cycle, one result per byte; the input stage holds one
// byte while a result waits, so the stream stalls only when the output does.
// Reset: synchronous, active low; clears the phase to await a control byte and
// sets the maximum remaining length to 262144. A halted block stays halted until reset.
module mqtt_fixed_header_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mfh_in_if.sink      i_stream,
    mfh_cfg_if.sink     i_cfg,
    mfh_out_if.source   o_result
);
    import mfh_pkg::*;

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_out_valid;
    t_result           r_out;
    logic [LEN_W-1:0]  r_max_len;

    logic              w_step;
    t_result           w_res;

    assign w_step          = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_stream.ready  = !r_in_valid || w_step;
    assign i_cfg.ready     = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_LEN_RESET;
        end else if (i_cfg.valid) begin
            r_max_len <= i_cfg.max_rem_length;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_stream.valid && i_stream.ready) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_stream.valid && i_stream.ready) begin
            r_in_byte <= i_stream.stream_byte;
        end
    end

    mfh_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (w_step),
        .i_byte    (r_in_byte),
        .i_max_len (r_max_len),
        .o_res     (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_res;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.event_res    = r_out.event_res;
    assign o_result.pkt_type     = r_out.pkt_type;
    assign o_result.packet_flags = r_out.packet_flags;
    assign o_result.rem_length   = r_out.rem_length;
    assign o_result.payload_byte = r_out.payload_byte;
    assign o_result.last         = r_out.last;

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// Testbench for mqtt_fixed_header_deframer: directed frames, random well-formed
// frames over several length limits, then one fatal framing error.
// Depends on mfh_pkg, mfh_if and the deframer RTL.
module tb;
    import mfh_pkg::*;

    localparam int QUIET_LIMIT = 2000;

    logic i_clk;
    logic i_rst_n;

    mfh_in_if  stream_if ();
    mfh_cfg_if cfg_if ();
    mfh_out_if result_if ();

    mqtt_fixed_header_deframer i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_stream (stream_if),
        .i_cfg    (cfg_if),
        .o_result (result_if)
    );

    // predicted deframer state
    t_phase           ph;
    logic [LEN_W-1:0] len_acc;
    logic [IDX_W-1:0] len_idx;
    logic [LEN_W-1:0] bytes_left;
    logic [NIB_W-1:0] hold_type;
    logic [NIB_W-1:0] hold_flags;
    logic [LEN_W-1:0] len_limit;

    t_result frame_events_due[$];
    int      mismatch_count;
    int      quiet_cycles;
    int      burst_left;
    int      bytes_sent;
    logic [15:0] stall_mask;
    int      stall_pos;

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    function automatic t_result deframe_byte(input logic [BYTE_W-1:0] b);
        t_result r;
        logic [IDX_W-1:0] k;
        r = '0;
        case (ph)
            PH_CONTROL: begin
                hold_type  = b[7:4];
                hold_flags = b[3:0];
                len_acc    = '0;
                len_idx    = '0;
                bytes_left = '0;
                ph         = PH_LENGTH;
                r.event_res = EV_HEADER;
            end
            PH_LENGTH: begin
                k = len_idx;
                len_acc = len_acc + (LEN_W'(b[6:0]) << (7 * k));
                if (b[7]) begin
                    if (k == LEN_IDX_LAST) begin
                        ph = PH_HALTED;
                        r.event_res = EV_BADLEN;
                    end else begin
                        len_idx = k + 1'b1;
                        r.event_res = EV_HEADER;
                    end
                end else if (len_acc > len_limit) begin
                    ph = PH_HALTED;
                    r.event_res = EV_TOOLARGE;
                    r.rem_length = len_acc;
                end else begin
                    bytes_left = len_acc;
                    if (bytes_left == 0) begin
                        ph = PH_CONTROL;
                    end else begin
                        ph = PH_PAYLOAD;
                    end
                    r.event_res = EV_COMPLETE;
                    r.rem_length = len_acc;
                    r.last = (bytes_left == 0);
                end
            end
            PH_PAYLOAD: begin
                bytes_left = bytes_left - 1'b1;
                if (bytes_left == 0) begin
                    ph = PH_CONTROL;
                end
                r.event_res = EV_PAYLOAD;
                r.rem_length = len_acc;
                r.payload_byte = b;
                r.last = (bytes_left == 0);
            end
            default: begin
                r.event_res = EV_DROPPED;
            end
        endcase
        r.pkt_type     = hold_type;
        r.packet_flags = hold_flags;
        return r;
    endfunction

    function automatic int length_bytes_needed(input logic [LEN_W-1:0] len);
        if (len < 128) return 1;
        if (len < 16384) return 2;
        if (len < 2097152) return 3;
        return 4;
    endfunction

    task automatic put_byte(input logic [BYTE_W-1:0] b);
        stream_if.valid       <= 1'b1;
        stream_if.stream_byte <= b;
        do @(posedge i_clk); while (!stream_if.ready);
        frame_events_due = {frame_events_due, deframe_byte(b)};
        bytes_sent = bytes_sent + 1;
        @(negedge i_clk);
        burst_left = burst_left - 1;
        if (burst_left <= 0) begin
            stream_if.valid       <= 1'b0;
            stream_if.stream_byte <= 8'($urandom);
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
            burst_left = $urandom_range(1, 40);
        end
    endtask

    task automatic stream_hold();
        stream_if.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (frame_events_due.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_max_length(input logic [LEN_W-1:0] value);
        stream_hold();
        wait_drained();
        cfg_if.valid          <= 1'b1;
        cfg_if.max_rem_length <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        len_limit = value;
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic send_length(input logic [LEN_W-1:0] len, input int n);
        for (int i = 0; i < n; i++) begin
            put_byte({i < n - 1, 7'(len >> (7 * i))});
        end
    endtask

    task automatic send_random_packet();
        logic [LEN_W-1:0] len;
        int n;
        case ($urandom_range(0, 19))
            0:       len = LEN_W'($urandom_range(100, 300));
            1, 2, 3, 4: len = LEN_W'($urandom_range(5, 24));
            default: len = LEN_W'($urandom_range(0, 4));
        endcase
        if (len > len_limit) begin
            len = LEN_W'($urandom_range(0, int'(len_limit)));
        end
        n = length_bytes_needed(len);
        if ($urandom_range(0, 4) == 0) begin
            n = $urandom_range(n, 4);
        end
        put_byte(8'($urandom));
        send_length(len, n);
        repeat (int'(len)) put_byte(8'($urandom));
    endtask

    task automatic test_directed_frames();
        put_byte(8'h00);
        put_byte(8'h00);
        put_byte(8'hFF);
        put_byte(8'h83);
        put_byte(8'h00);
        put_byte(8'hFF);
        put_byte(8'h00);
        put_byte(8'h5A);
        put_byte(8'h32);
        put_byte(8'h82);
        put_byte(8'h80);
        put_byte(8'h80);
        put_byte(8'h00);
        put_byte(8'hA5);
        put_byte(8'h80);
        put_byte(8'hE0);
        put_byte(8'h00);
        // change the limit in the middle of a length field
        put_byte(8'h30);
        put_byte(8'h85);
        write_max_length(LEN_W'(5));
        put_byte(8'h00);
        repeat (5) put_byte(8'($urandom));
    endtask

    task automatic test_limit_sweep();
        logic [LEN_W-1:0] limits[7];
        int target;
        limits[0] = 28'h0FFFFFFF;
        limits[1] = '0;
        limits[2] = LEN_W'($urandom_range(1, 40));
        limits[3] = LEN_W'(127);
        limits[4] = LEN_W'(128);
        limits[5] = LEN_W'($urandom);
        limits[6] = MAX_LEN_RESET;
        foreach (limits[p]) begin
            write_max_length(limits[p]);
            target = bytes_sent + 80;
            while (bytes_sent < target) begin
                send_random_packet();
                if ($urandom_range(0, 24) == 0) begin
                    stream_hold();
                    wait_drained();
                end
            end
        end
    endtask

    task automatic test_error_halt();
        logic [LEN_W-1:0] limit;
        logic [LEN_W-1:0] len;
        int n;
        if ($urandom_range(0, 1) == 1) begin
            limit = ($urandom_range(0, 3) == 0) ? '0 : LEN_W'($urandom_range(1, 50000));
            write_max_length(limit);
            repeat (2) send_random_packet();
            if ($urandom_range(0, 1) == 1) begin
                len = limit + 1'b1;
            end else begin
                len = LEN_W'($urandom_range(int'(limit) + 1, 28'h0FFFFFFF));
            end
            n = $urandom_range(length_bytes_needed(len), 4);
            put_byte(8'($urandom));
            send_length(len, n);
        end else begin
            send_random_packet();
            put_byte(8'($urandom));
            repeat (4) put_byte(8'h80 | 8'($urandom_range(0, 127)));
        end
        put_byte(8'h00);
        put_byte(8'hFF);
        repeat ($urandom_range(8, 16)) put_byte(8'($urandom));
    endtask

    always @(negedge i_clk) begin
        if (stall_pos == 0) begin
            case ($urandom_range(0, 3))
                0:       stall_mask = 16'hFFFF;
                1:       stall_mask = 16'($urandom);
                2:       stall_mask = 16'($urandom) | 16'($urandom);
                default: stall_mask = 16'($urandom) & 16'($urandom);
            endcase
        end
        result_if.ready <= stall_mask[stall_pos];
        stall_pos = (stall_pos + 1) % 16;
    end

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && result_if.valid && result_if.ready) begin
            if (frame_events_due.size() == 0) begin
                mismatch_count = mismatch_count + 1;
                if (mismatch_count <= 10) begin
                    $display("unexpected result: ev=%0d type=%0d flags=%0d len=%0d pb=%0d last=%0d",
                             result_if.event_res, result_if.pkt_type,
                             result_if.packet_flags, result_if.rem_length,
                             result_if.payload_byte, result_if.last);
                end
            end else begin
                want = frame_events_due.pop_front();
                if (result_if.event_res !== want.event_res
                        || result_if.pkt_type !== want.pkt_type
                        || result_if.packet_flags !== want.packet_flags
                        || result_if.rem_length !== want.rem_length
                        || result_if.payload_byte !== want.payload_byte
                        || result_if.last !== want.last) begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= 10) begin
                        $display("mismatch exp: ev=%0d type=%0d flags=%0d len=%0d pb=%0d last=%0d",
                                 want.event_res, want.pkt_type, want.packet_flags,
                                 want.rem_length, want.payload_byte, want.last);
                        $display("         act: ev=%0d type=%0d flags=%0d len=%0d pb=%0d last=%0d",
                                 result_if.event_res, result_if.pkt_type,
                                 result_if.packet_flags, result_if.rem_length,
                                 result_if.payload_byte, result_if.last);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((stream_if.valid && stream_if.ready) || (cfg_if.valid && cfg_if.ready)
                || (result_if.valid && result_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        stream_if.valid       = 1'b0;
        stream_if.stream_byte = '0;
        cfg_if.valid          = 1'b0;
        cfg_if.max_rem_length = '0;
        result_if.ready       = 1'b0;
        i_rst_n               = 1'b0;
        ph             = PH_CONTROL;
        len_acc        = '0;
        len_idx        = '0;
        bytes_left     = '0;
        hold_type      = '0;
        hold_flags     = '0;
        len_limit      = MAX_LEN_RESET;
        mismatch_count = 0;
        quiet_cycles   = 0;
        bytes_sent     = 0;
        stall_pos      = 0;
        stall_mask     = 16'hFFFF;
        burst_left     = $urandom_range(1, 40);
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_frames();
        test_limit_sweep();
        test_error_halt();
        stream_hold();
        wait_drained();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
